FILE: hdl/lbp_pkg.sv
`default_nettype none
package lbp_pkg;

  // Item kinds carried on the input tuser
  localparam logic [1:0] OP_PUT_BIT  = 2'd0;
  localparam logic [1:0] OP_PUT_BYTE = 2'd1;
  localparam logic [1:0] OP_ALIGN    = 2'd2;

  localparam int unsigned MaxAlignLog2Default = 3;

  // Command queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam int unsigned InDataW  = 24;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 8;

  // One queued command: an optional lead byte, then a run of pad bytes
  typedef struct packed {
    logic       first_valid;
    logic [7:0] first_byte;
    logic [2:0] pad_count;
    logic [7:0] pad_byte;
  } lbp_cmd_t;

endpackage
`default_nettype wire

FILE: hdl/lbp_queue.sv
`default_nettype none
module lbp_queue
  import lbp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire lbp_cmd_t push_cmd_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output lbp_cmd_t      pop_cmd_o,
  output logic          empty_o
);

  lbp_cmd_t             slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 do_push, do_pop;

  assign full_o    = (count_q == QueueCntW'(QueueDepth));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_cmd_o = slot_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/lbp_front.sv
`default_nettype none
module lbp_front
  import lbp_pkg::*;
#(
  parameter int unsigned MAX_ALIGN_LOG2 = MaxAlignLog2Default
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [InDataW-1:0] s_axis_tdata,
  input  wire logic [InUserW-1:0] s_axis_tuser,
  output logic                    push_o,
  output lbp_cmd_t                push_cmd_o,
  input  wire logic               full_i
);

  localparam int unsigned AlignLim = (MAX_ALIGN_LOG2 > 3) ? 3 : MAX_ALIGN_LOG2;

  logic [6:0] partial_q, partial_d;
  logic [2:0] bit_count_q, bit_count_d;
  logic [2:0] offset_q, offset_d;

  logic        accept;
  logic [1:0]  op;
  logic        bit_val;
  logic [7:0]  byte_val;
  logic [1:0]  align_log2;
  logic [7:0]  pad_val;
  logic [7:0]  low_mask;
  logic [6:0]  cur;
  logic [14:0] word;
  logic [1:0]  alog;
  logic [2:0]  align_mask;
  logic [2:0]  off_after_lead;
  logic [2:0]  pads;
  lbp_cmd_t    cmd;

  assign op         = s_axis_tuser;
  assign bit_val    = s_axis_tdata[0];
  assign byte_val   = s_axis_tdata[8:1];
  assign align_log2 = s_axis_tdata[10:9];
  assign pad_val    = s_axis_tdata[18:11];

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && !full_i;

  // Classify the request and work out the bytes it causes
  always_comb begin
    low_mask       = 8'((9'd1 << bit_count_q) - 9'd1);
    cur            = partial_q & low_mask[6:0];
    word           = 15'(cur) | (15'(byte_val) << bit_count_q);
    alog           = (align_log2 > 2'(AlignLim)) ? 2'(AlignLim) : align_log2;
    align_mask     = 3'((4'd1 << alog) - 4'd1);
    off_after_lead = offset_q + 3'(bit_count_q != 3'd0);
    pads           = (3'd0 - off_after_lead) & align_mask;

    cmd         = '0;
    cmd.pad_byte = pad_val;
    partial_d   = partial_q;
    bit_count_d = bit_count_q;
    offset_d    = offset_q;

    unique case (op)
      OP_PUT_BIT: begin
        if (bit_count_q == 3'd7) begin
          cmd.first_valid = 1'b1;
          cmd.first_byte  = {bit_val, cur};
          partial_d       = '0;
          bit_count_d     = '0;
          offset_d        = offset_q + 3'd1;
        end else begin
          partial_d   = cur | (7'(bit_val) << bit_count_q);
          bit_count_d = bit_count_q + 3'd1;
        end
      end
      OP_PUT_BYTE: begin
        cmd.first_valid = 1'b1;
        cmd.first_byte  = word[7:0];
        partial_d       = word[14:8];
        offset_d        = offset_q + 3'd1;
      end
      OP_ALIGN: begin
        cmd.first_valid = (bit_count_q != 3'd0);
        cmd.first_byte  = {1'b0, cur} | (pad_val & ~low_mask);
        cmd.pad_count   = pads;
        partial_d       = '0;
        bit_count_d     = '0;
        offset_d        = off_after_lead + pads;
      end
      default: begin
        // unused kind: no bytes, no state change
      end
    endcase
  end

  assign push_o     = accept && (cmd.first_valid || (cmd.pad_count != 3'd0));
  assign push_cmd_o = cmd;

  // Packer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= '0;
      bit_count_q <= '0;
      offset_q    <= '0;
    end else if (accept) begin
      partial_q   <= partial_d;
      bit_count_q <= bit_count_d;
      offset_q    <= offset_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/lbp_back.sv
`default_nettype none
module lbp_back
  import lbp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                empty_i,
  input  wire lbp_cmd_t            cmd_i,
  output logic                     pop_o,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tlast
);

  logic       busy_q;
  logic       lead_q;
  logic [2:0] pads_left_q;
  logic [7:0] lead_byte_q;
  logic [7:0] pad_byte_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       out_free;
  logic       is_last;

  assign out_free = !out_valid_q || m_axis_tready;
  assign pop_o    = !busy_q && !empty_i;
  assign is_last  = lead_q ? (pads_left_q == 3'd0) : (pads_left_q == 3'd1);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

  // Command payload and output byte/last registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      lead_byte_q <= cmd_i.first_byte;
      pad_byte_q  <= cmd_i.pad_byte;
    end
    if (busy_q && out_free) begin
      out_byte_q <= lead_q ? lead_byte_q : pad_byte_q;
      out_last_q <= is_last;
    end
  end

  // Run sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      lead_q      <= 1'b0;
      pads_left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q      <= 1'b1;
        lead_q      <= cmd_i.first_valid;
        pads_left_q <= cmd_i.pad_count;
      end else if (busy_q && out_free) begin
        if (lead_q) begin
          lead_q <= 1'b0;
        end else begin
          pads_left_q <= pads_left_q - 3'd1;
        end
        if (is_last) begin
          busy_q <= 1'b0;
        end
      end
      if (busy_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/lsb_first_bit_packer_top.sv
`default_nettype none
// Channel    Dir  Signals                 Contents
// s_axis     in   tvalid/tready/tdata/    requests: put bit, put byte, align
//                 tuser
// m_axis     out  tvalid/tready/tdata/    packed bytes, tlast on the final
//                 tlast                   byte of each request
//
// A request is taken while the two-entry command queue has room. Each
// byte-producing request is loaded by the back end, then sends one byte per
// cycle while the output is not stalled (up to eight for an align); the back
// end sets the rate. Requests that produce no byte never enter the queue.
// Reset (rst_ni low) clears packer state, queue and output register.
// Output stalls fill the queue and then drop s_axis_tready.
module lsb_first_bit_packer_top
  import lbp_pkg::*;
#(
  parameter int unsigned MAX_ALIGN_LOG2 = MaxAlignLog2Default
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // bit_value[0], byte_value[8:1], align_log2[10:9], pad_value[18:11], zero above
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // operation[1:0]
  input  wire logic [InUserW-1:0]  s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // out_byte[7:0]
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tlast
);

  logic     push, full, pop, empty;
  lbp_cmd_t push_cmd, pop_cmd;

  lbp_front #(
    .MAX_ALIGN_LOG2(MAX_ALIGN_LOG2)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_o        (push),
    .push_cmd_o    (push_cmd),
    .full_i        (full)
  );

  lbp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (empty)
  );

  lbp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .cmd_i         (pop_cmd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire
